// ===== rtl/biou_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_pkg
// Shared widths and payload types of the box overlap ratio block.
// ----------------------------------------------------------------------------
package biou_pkg;

    // width of one coordinate field on the input port
    localparam int FIELD_BITS          = 16;
    // default number of coordinate bits taken from each field
    localparam int COORD_BITS_DEFAULT  = 16;
    // fraction bits of the ratio; fixes the output field width
    localparam int FRAC_BITS           = 16;
    localparam int RATIO_BITS          = FRAC_BITS + 1;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] a_left;
        logic signed [FIELD_BITS-1:0] a_top;
        logic signed [FIELD_BITS-1:0] a_right;
        logic signed [FIELD_BITS-1:0] a_bottom;
        logic signed [FIELD_BITS-1:0] b_left;
        logic signed [FIELD_BITS-1:0] b_top;
        logic signed [FIELD_BITS-1:0] b_right;
        logic signed [FIELD_BITS-1:0] b_bottom;
    } t_box_pair;

    typedef struct packed {
        logic [RATIO_BITS-1:0] overlap_ratio;
        logic                  empty_union;
    } t_iou_result;

endpackage

// ===== rtl/box_intersection_over_union_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_intersection_over_union_unit
// Intersection over union of two axis-aligned boxes, unsigned Q1.FRAC_BITS,
// saturated at 1.0, with a flag for an empty union.
// ----------------------------------------------------------------------------
//  channel | valid      | ready      | payload
//  --------+------------+------------+------------------------------------
//  in      | i_in_valid | o_in_ready | i_in  (biou_pkg::t_box_pair)
//  out     | o_out_valid| i_out_ready| o_out (biou_pkg::t_iou_result)
//
//  One box pair per cycle while the skid entry is empty. The restoring
//  divider computes one quotient bit per pipeline stage, behind four
//  stages of extents, areas and union. Synchronous active-low reset
//  clears all valid bits; no state otherwise. A two-entry output
//  (register plus skid) lets the pipeline take a transfer while a result
//  waits; o_in_ready drops only when both entries are full.
// ----------------------------------------------------------------------------
module box_intersection_over_union_unit #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  biou_pkg::t_box_pair   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output biou_pkg::t_iou_result o_out
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = 2 * CW;
    localparam int UW   = AW + 1;
    localparam int F    = biou_pkg::FRAC_BITS;
    localparam int FB   = biou_pkg::FIELD_BITS;
    localparam int TAKE = (CW < FB) ? CW : FB;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    function automatic logic signed [CW-1:0] f_coord(input logic [FB-1:0] raw);
        return signed'(CW'(raw[TAKE-1:0]));
    endfunction

    function automatic logic [CW-1:0] f_absdiff(input logic signed [CW-1:0] hi,
                                                input logic signed [CW-1:0] lo);
        logic signed [CW:0] d_pos;
        logic signed [CW:0] d_neg;
        d_pos = (CW+1)'(hi) - (CW+1)'(lo);
        d_neg = (CW+1)'(lo) - (CW+1)'(hi);
        return (hi >= lo) ? d_pos[CW-1:0] : d_neg[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] f_extent(input logic signed [CW-1:0] lo,
                                               input logic signed [CW-1:0] hi);
        logic signed [CW:0] d;
        d = (CW+1)'(hi) - (CW+1)'(lo);
        return (hi > lo) ? d[CW-1:0] : '0;
    endfunction

    logic en;

    // ---------------- stage 1: box extents, edge max/min ----------------
    logic signed [CW-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic                 r_v1;
    logic [CW-1:0]        r1_wa, r1_ha, r1_wb, r1_hb;
    logic signed [CW-1:0] r1_xl, r1_xr, r1_yt, r1_yb;

    always_comb begin
        al = f_coord(i_in.a_left);
        at = f_coord(i_in.a_top);
        ar = f_coord(i_in.a_right);
        ab = f_coord(i_in.a_bottom);
        bl = f_coord(i_in.b_left);
        bt = f_coord(i_in.b_top);
        br = f_coord(i_in.b_right);
        bb = f_coord(i_in.b_bottom);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_wa <= f_absdiff(ar, al);
            r1_ha <= f_absdiff(ab, at);
            r1_wb <= f_absdiff(br, bl);
            r1_hb <= f_absdiff(bb, bt);
            r1_xl <= (al < bl) ? bl : al;
            r1_yt <= (at < bt) ? bt : at;
            r1_xr <= (ar < br) ? ar : br;
            r1_yb <= (ab < bb) ? ab : bb;
        end
    end

    // ---------------- stage 2: intersection extents ----------------
    logic          r_v2;
    logic [CW-1:0] r2_wa, r2_ha, r2_wb, r2_hb, r2_iw, r2_ih;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_wa <= r1_wa;
            r2_ha <= r1_ha;
            r2_wb <= r1_wb;
            r2_hb <= r1_hb;
            r2_iw <= f_extent(r1_xl, r1_xr);
            r2_ih <= f_extent(r1_yt, r1_yb);
        end
    end

    // ---------------- stage 3: areas ----------------
    logic          r_v3;
    logic [AW-1:0] r3_area_a, r3_area_b, r3_inter;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_area_a <= AW'(r2_wa) * AW'(r2_ha);
            r3_area_b <= AW'(r2_wb) * AW'(r2_hb);
            r3_inter  <= AW'(r2_iw) * AW'(r2_ih);
        end
    end

    // ---------------- stage 4: union ----------------
    logic          r_v4;
    logic [UW-1:0] r4_uni;
    logic [AW-1:0] r4_inter;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_uni   <= UW'(r3_area_a) + UW'(r3_area_b) - UW'(r3_inter);
            r4_inter <= r3_inter;
        end
    end

    // ---------------- divider: init stage then one bit per stage ----------------
    // intersection never exceeds the union, so the integer bit is set only
    // for a ratio of exactly 1.0 and the remainder starts below the union
    logic          r_dv   [0:F];
    logic          r_emp  [0:F];
    logic [UW-1:0] r_uni  [0:F];
    logic [UW-1:0] r_rem  [0:F];
    logic [F:0]    r_q    [0:F];
    logic [UW-1:0] n_rem  [1:F];
    logic [F:0]    n_q    [1:F];
    logic          q0;

    assign q0 = (UW'(r4_inter) >= r4_uni);

    always_comb begin
        for (int j = 1; j <= F; j++) begin
            logic [UW:0] t;
            logic        ge;
            t  = {r_rem[j-1], 1'b0};
            ge = (t >= {1'b0, r_uni[j-1]});
            n_rem[j] = ge ? UW'(t - {1'b0, r_uni[j-1]}) : t[UW-1:0];
            n_q[j]   = {r_q[j-1][F-1:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_emp[0] <= (r4_uni == '0);
            r_uni[0] <= r4_uni;
            r_rem[0] <= q0 ? UW'(UW'(r4_inter) - r4_uni) : UW'(r4_inter);
            r_q[0]   <= (F+1)'(q0);
            for (int j = 1; j <= F; j++) begin
                r_emp[j] <= r_emp[j-1];
                r_uni[j] <= r_uni[j-1];
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int j = 0; j <= F; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else if (en) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_dv[0] <= r_v4;
            for (int j = 1; j <= F; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
        end
    end

    // ---------------- output register and skid ----------------
    biou_pkg::t_iou_result n_res;
    biou_pkg::t_iou_result r_out;
    biou_pkg::t_iou_result r_skid;
    logic                  r_out_v;
    logic                  r_skid_v;
    logic                  push;

    always_comb begin
        n_res.empty_union   = r_emp[F];
        if (r_emp[F]) begin
            n_res.overlap_ratio = '0;
        end else if (r_q[F] > ONE) begin
            n_res.overlap_ratio = ONE;
        end else begin
            n_res.overlap_ratio = r_q[F];
        end
    end

    assign en   = !r_skid_v;
    assign push = en && r_dv[F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (i_out_ready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (push && r_out_v && !i_out_ready) begin
                r_skid_v <= 1'b1;
            end
            if (r_skid_v || push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_v || i_out_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// ===== rtl/biou_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_checker
// Port-level checks of the box overlap ratio block, bound to the top level.
// ----------------------------------------------------------------------------
module biou_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input biou_pkg::t_box_pair   i_in,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input biou_pkg::t_iou_result o_out
);

    localparam logic [biou_pkg::RATIO_BITS-1:0] ONE =
        {1'b1, {biou_pkg::FRAC_BITS{1'b0}}};

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    // input back-pressure only when a result is waiting
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // input back-pressure comes from a stalled output transfer
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");

    // empty union forces a zero ratio; ratio never above 1.0
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.overlap_ratio <= ONE) &&
                        (!o_out.empty_union || o_out.overlap_ratio == '0))
        else $error("ratio out of range");

endmodule

bind box_intersection_over_union_unit biou_checker u_biou_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box overlap ratio unit. Box pairs go in over
// a valid/ready channel in random bursts. The receiver stalls in shifting
// patterns and holds off once for a long stretch so that the pipeline fills.
// A scoreboard predicts intersection over union for every accepted pair and
// compares each output transfer, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY      = biou_pkg::FRAC_BITS + 6;
    localparam int RANDOM_PAIRS = 1250;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam longint ONE_Q    = longint'(1) << biou_pkg::FRAC_BITS;

    // ------------------------------------------------------------------------
    // expected-result store and ratio prediction
    // ------------------------------------------------------------------------
    class iou_scoreboard;
        biou_pkg::t_iou_result expected_q[$];
        int                    errors;

        function new();
            errors = 0;
        endfunction

        function longint span(longint hi, longint lo);
            return (hi >= lo) ? hi - lo : lo - hi;
        endfunction

        function longint overlap_len(longint lo, longint hi);
            return (hi > lo) ? hi - lo : 0;
        endfunction

        function biou_pkg::t_iou_result predict_iou(biou_pkg::t_box_pair p);
            longint al, at, ar, ab, bl, bt, br, bb;
            longint area_a, area_b, inter, uni, q;
            biou_pkg::t_iou_result r;
            al = $signed(p.a_left);
            at = $signed(p.a_top);
            ar = $signed(p.a_right);
            ab = $signed(p.a_bottom);
            bl = $signed(p.b_left);
            bt = $signed(p.b_top);
            br = $signed(p.b_right);
            bb = $signed(p.b_bottom);
            area_a = span(ar, al) * span(ab, at);
            area_b = span(br, bl) * span(bb, bt);
            inter  = overlap_len((al > bl) ? al : bl, (ar < br) ? ar : br) *
                     overlap_len((at > bt) ? at : bt, (ab < bb) ? ab : bb);
            uni    = area_a + area_b - inter;
            if (uni == 0) begin
                r.overlap_ratio = '0;
                r.empty_union   = 1'b1;
            end else begin
                q = (inter << biou_pkg::FRAC_BITS) / uni;
                if (q > ONE_Q) q = ONE_Q;
                r.overlap_ratio = q[biou_pkg::RATIO_BITS-1:0];
                r.empty_union   = 1'b0;
            end
            return r;
        endfunction

        function void note_pair(biou_pkg::t_box_pair p);
            expected_q.push_back(predict_iou(p));
        endfunction

        function void check_result(biou_pkg::t_iou_result got);
            biou_pkg::t_iou_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result ratio=%0d empty=%0b",
                         $time, got.overlap_ratio, got.empty_union);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.overlap_ratio !== want.overlap_ratio) begin
                $display("%0t: overlap_ratio expected %0d actual %0d",
                         $time, want.overlap_ratio, got.overlap_ratio);
                errors++;
            end
            if (got.empty_union !== want.empty_union) begin
                $display("%0t: empty_union expected %0b actual %0b",
                         $time, want.empty_union, got.empty_union);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    biou_pkg::t_box_pair   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    biou_pkg::t_iou_result o_out;

    logic        hold_request = 1'b0;
    int          quiet_cycles = 0;

    iou_scoreboard sb;

    box_intersection_over_union_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic biou_pkg::t_box_pair pack_pair(int al, int at, int ar, int ab,
                                                      int bl, int bt, int br, int bb);
        biou_pkg::t_box_pair p;
        p.a_left   = 16'(al);
        p.a_top    = 16'(at);
        p.a_right  = 16'(ar);
        p.a_bottom = 16'(ab);
        p.b_left   = 16'(bl);
        p.b_top    = 16'(bt);
        p.b_right  = 16'(br);
        p.b_bottom = 16'(bb);
        return p;
    endfunction

    function automatic biou_pkg::t_box_pair make_random_pair();
        int kind, cx, cy, w, h, dx, dy, bw, bh, t;
        int c[8];
        kind = $urandom_range(0, 99);
        cx = int'($urandom_range(0, 60000)) - 30000;
        cy = int'($urandom_range(0, 60000)) - 30000;
        if ($urandom_range(0, 9) == 0) begin
            w  = $urandom_range(0, 30000);
            h  = $urandom_range(0, 30000);
        end else begin
            w  = $urandom_range(0, 400);
            h  = $urandom_range(0, 400);
        end
        bw = $urandom_range(0, w + 20);
        bh = $urandom_range(0, h + 20);
        dx = int'($urandom_range(0, 2 * w + 40)) - w - 20;
        dy = int'($urandom_range(0, 2 * h + 40)) - h - 20;
        c[0] = cx;      c[1] = cy;      c[2] = cx + w;       c[3] = cy + h;
        c[4] = cx + dx; c[5] = cy + dy; c[6] = cx + dx + bw; c[7] = cy + dy + bh;
        if (kind < 15) begin
            for (int i = 0; i < 8; i++) c[i] = int'($urandom());
        end else if (kind < 65) begin
            // overlapping or nearby boxes, left as built
        end else if (kind < 75) begin
            // each box may be inverted on either axis, each swap at random
            if ($urandom_range(0, 1)) begin t = c[0]; c[0] = c[2]; c[2] = t; end
            if ($urandom_range(0, 1)) begin t = c[1]; c[1] = c[3]; c[3] = t; end
            if ($urandom_range(0, 1)) begin t = c[4]; c[4] = c[6]; c[6] = t; end
            if ($urandom_range(0, 1)) begin t = c[5]; c[5] = c[7]; c[7] = t; end
        end else if (kind < 83) begin
            // degenerate boxes, both degenerate gives an empty union
            if ($urandom_range(0, 1)) c[2] = c[0]; else c[3] = c[1];
            if ($urandom_range(0, 1)) begin
                if ($urandom_range(0, 1)) c[6] = c[4]; else c[7] = c[5];
            end
        end else if (kind < 92) begin
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(0, 4))
                    0: c[i] = -32768;
                    1: c[i] = 32767;
                    2: c[i] = 0;
                    3: c[i] = -1;
                    default: c[i] = int'($urandom());
                endcase
            end
        end else if (kind < 96) begin
            for (int i = 0; i < 4; i++) c[i+4] = c[i];
        end else begin
            // B inside A
            c[4] = c[0] + w / 4; c[5] = c[1] + h / 4;
            c[6] = c[2] - w / 4; c[7] = c[3] - h / 4;
        end
        return pack_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    task automatic send_pair(biou_pkg::t_box_pair p);
        i_in       <= p;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pair(p);
    endtask

    // a zero-length gap keeps valid up so the next pair follows directly
    task automatic idle_cycles(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        send_pair(pack_pair(0, 0, 10, 10, 20, 20, 30, 30));
        send_pair(pack_pair(0, 0, 10, 10, 10, 0, 20, 10));
        send_pair(pack_pair(0, 0, 100, 100, 25, 25, 75, 75));
        send_pair(pack_pair(10, 10, 0, 0, 0, 0, 10, 10));
        send_pair(pack_pair(10, 10, 0, 0, 10, 10, 0, 0));
        send_pair(pack_pair(0, 20, 20, 0, 0, 0, 20, 20));
        send_pair(pack_pair(5, 0, 5, 10, 0, 0, 10, 10));
        send_pair(pack_pair(0, 0, 0, 5, 3, 3, 8, 3));
        send_pair(pack_pair(0, 0, 10, 10, 5, 0, 15, 10));
        send_pair(pack_pair(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767));
        send_pair(pack_pair(-32768, 0, 32767, 1, -32768, 0, 32767, 1));
        send_pair(pack_pair(-1, -1, 0, 0, 0, 0, 1, 1));
        send_pair(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pack_pair(0, 0, 1000, 1000, 0, 0, 1000, 999));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, 0, 0, 0, 0));
        send_pair(pack_pair(-32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767));
    endtask

    task automatic run_random(int count);
        int burst;
        burst = $urandom_range(1, 40);
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(1, 40);
            end
            if (n == 300) hold_request <= 1'b1;
            send_pair(make_random_pair());
            burst--;
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int left;
        int cyc;
        bit hold_done;
        mode = 0;
        left = 0;
        cyc = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_request && !hold_done) begin
                // long hold-off: the pipeline fills and input ready drops
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (cyc % 5 < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(RANDOM_PAIRS);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
